// File: sv/thkr_pkg.sv
// Shared types and constants of the tap/hold key resolver.
// Used by the channel interfaces' users, the front end, the back end and the top level.
package thkr_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [15:0] TAPPING_TERM_RST  = 16'd200;
  localparam logic        HOLD_OTHER_RST    = 1'b0;
  localparam logic [7:0]  TAP_TIMEOUT_RST   = 8'd20;

  typedef enum logic [1:0] {
    CFG_TAPPING_TERM = 2'd0,
    CFG_HOLD_OTHER   = 2'd1,
    CFG_TAP_TIMEOUT  = 2'd2
  } thkr_cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_ORDINARY  = 2'd0,
    KIND_MOD_TAP   = 2'd1,
    KIND_LAYER_TAP = 2'd2
  } thkr_kind_t;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_UNDECIDED = 2'd1,
    PH_HELD      = 2'd2
  } thkr_phase_t;

  typedef enum logic [2:0] {
    HA_NONE      = 3'd0,
    HA_MODS_ON   = 3'd1,
    HA_MODS_OFF  = 3'd2,
    HA_LAYER_ON  = 3'd3,
    HA_LAYER_OFF = 3'd4
  } thkr_hold_act_t;

  typedef enum logic [1:0] {
    TA_NONE  = 2'd0,
    TA_REG   = 2'd1,
    TA_UNREG = 2'd2
  } thkr_tap_act_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    logic        is_tick;
    logic        is_dual;
    logic        is_layer;
    logic [31:0] now_ms;
    logic [3:0]  key_row;
    logic [4:0]  key_col;
    logic        is_press;
    logic [7:0]  hold_mod_mask;
    logic [3:0]  hold_layer_num;
    logic [7:0]  tap_key_code;
    logic        host_flushed;
  } thkr_item_t;

  typedef struct packed {
    logic       valid;
    thkr_item_t item;
  } thkr_qhead_t;

  typedef struct packed {
    thkr_phase_t phase;
    logic        release_pending;
  } thkr_stat_t;

endpackage

// File: sv/thkr_in_if.sv
// Input request channel of the tap/hold key resolver.
// Stand-alone valid/ready interface; no package dependency.
interface thkr_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] now_ms;
  logic [3:0]  key_row;
  logic [4:0]  key_col;
  logic        is_press;
  logic [1:0]  key_kind;
  logic [7:0]  hold_mod_mask;
  logic [3:0]  hold_layer_num;
  logic [7:0]  tap_key_code;
  logic        host_flushed;

  modport source (
    output valid, cmd, now_ms, key_row, key_col, is_press, key_kind,
           hold_mod_mask, hold_layer_num, tap_key_code, host_flushed,
    input  ready
  );

  modport sink (
    input  valid, cmd, now_ms, key_row, key_col, is_press, key_kind,
           hold_mod_mask, hold_layer_num, tap_key_code, host_flushed,
    output ready
  );
endinterface

// File: sv/thkr_out_if.sv
// Result channel of the tap/hold key resolver.
// Stand-alone valid/ready interface; no package dependency.
interface thkr_out_if;
  logic       valid;
  logic       ready;
  logic       pass_on;
  logic       tap_counted;
  logic [2:0] hold_action;
  logic [7:0] action_mods;
  logic [3:0] action_layer;
  logic [1:0] tap_action;
  logic [7:0] tap_code_out;

  modport source (
    output valid, pass_on, tap_counted, hold_action, action_mods, action_layer,
           tap_action, tap_code_out,
    input  ready
  );

  modport sink (
    input  valid, pass_on, tap_counted, hold_action, action_mods, action_layer,
           tap_action, tap_code_out,
    output ready
  );
endinterface

// File: sv/thkr_front.sv
// Front end: accepts requests, classifies them and holds them in a short queue.
// Depends on thkr_pkg and thkr_in_if.
module thkr_front #(
  parameter int unsigned QDEPTH = thkr_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  thkr_in_if.sink             in_ch,
  input  logic                pop,
  output thkr_pkg::thkr_qhead_t head
);

  localparam int unsigned PW = $clog2(QDEPTH);
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  thkr_pkg::thkr_item_t q_r [QDEPTH];
  thkr_pkg::thkr_item_t item_in;

  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          push;
  logic          do_pop;

  assign in_ch.ready = (cnt_r < CW'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign do_pop      = pop && (cnt_r != '0);

  // Kind code 3 has no meaning and falls in with ordinary keys.
  always_comb begin
    item_in.is_tick        = in_ch.cmd;
    item_in.is_dual        = (in_ch.key_kind == thkr_pkg::KIND_MOD_TAP) ||
                             (in_ch.key_kind == thkr_pkg::KIND_LAYER_TAP);
    item_in.is_layer       = (in_ch.key_kind == thkr_pkg::KIND_LAYER_TAP);
    item_in.now_ms         = in_ch.now_ms;
    item_in.key_row        = in_ch.key_row;
    item_in.key_col        = in_ch.key_col;
    item_in.is_press       = in_ch.is_press;
    item_in.hold_mod_mask  = in_ch.hold_mod_mask;
    item_in.hold_layer_num = in_ch.hold_layer_num;
    item_in.tap_key_code   = in_ch.tap_key_code;
    item_in.host_flushed   = in_ch.host_flushed;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item_in;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.item  = q_r[rd_ptr_r];

endmodule

// File: sv/thkr_back.sv
// Back end: resolves the queued request against the tap/hold state and
// registers the result. Holds the configuration registers. Depends on thkr_pkg.
module thkr_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_idx,
  input  logic [15:0]           cfg_wdata,
  input  thkr_pkg::thkr_qhead_t head,
  output logic                  pop,
  thkr_out_if.source            out_ch,
  output thkr_pkg::thkr_stat_t  stat
);

  // Configuration
  logic [15:0] term_r;
  logic        hold_other_r;
  logic [7:0]  timeout_r;

  // Resolver state
  thkr_pkg::thkr_phase_t phase_r, phase_nxt;
  logic [3:0]  pending_row_r, pending_row_nxt;
  logic [4:0]  pending_col_r, pending_col_nxt;
  logic        pending_is_layer_r, pending_is_layer_nxt;
  logic [7:0]  pending_mods_r, pending_mods_nxt;
  logic [3:0]  pending_layer_r, pending_layer_nxt;
  logic [7:0]  pending_tap_code_r, pending_tap_code_nxt;
  logic [31:0] press_time_r, press_time_nxt;
  logic [7:0]  kept_mods_r, kept_mods_nxt;
  logic [3:0]  kept_layer_r, kept_layer_nxt;
  logic        kept_is_layer_r, kept_is_layer_nxt;
  logic        rel_pend_r, rel_pend_nxt;
  logic [7:0]  release_code_r, release_code_nxt;
  logic [31:0] tap_time_r, tap_time_nxt;

  // Result register
  logic                     out_valid_r, out_valid_nxt;
  logic                     pass_r, pass_nxt;
  logic                     tap_cnt_r, tap_cnt_nxt;
  thkr_pkg::thkr_hold_act_t ha_r, ha_nxt;
  logic [7:0]               amods_r, amods_nxt;
  logic [3:0]               alayer_r, alayer_nxt;
  thkr_pkg::thkr_tap_act_t  ta_r, ta_nxt;
  logic [7:0]               tcode_r, tcode_nxt;

  thkr_pkg::thkr_item_t it;
  logic [31:0] since_press;
  logic [31:0] since_tap;
  logic        other_pos;
  logic        do_hold, do_unreg, do_new, do_tap, do_end;

  assign it  = head.item;
  assign pop = head.valid && (!out_valid_r || out_ch.ready);

  assign since_press = it.now_ms - press_time_r;
  assign since_tap   = it.now_ms - tap_time_r;
  assign other_pos   = (it.key_row != pending_row_r) || (it.key_col != pending_col_r);

  // Decide what this request does.
  always_comb begin
    do_hold  = 1'b0;
    do_unreg = 1'b0;
    do_new   = 1'b0;
    do_tap   = 1'b0;
    do_end   = 1'b0;
    pass_nxt = 1'b0;
    if (it.is_tick) begin
      do_hold  = (phase_r == thkr_pkg::PH_UNDECIDED) && (since_press >= {16'b0, term_r});
      do_unreg = rel_pend_r && (it.host_flushed || (since_tap > {24'b0, timeout_r}));
    end else if ((phase_r != thkr_pkg::PH_IDLE) && other_pos) begin
      do_hold  = it.is_press && (phase_r == thkr_pkg::PH_UNDECIDED) && hold_other_r;
      pass_nxt = 1'b1;
    end else if (it.is_dual) begin
      if (it.is_press) begin
        // A repeat press while undecided holds the old key first.
        do_hold = (phase_r == thkr_pkg::PH_UNDECIDED);
        do_new  = 1'b1;
      end else if (phase_r == thkr_pkg::PH_UNDECIDED) begin
        do_tap = 1'b1;
      end else if (phase_r == thkr_pkg::PH_HELD) begin
        do_end = 1'b1;
      end
    end else begin
      pass_nxt = 1'b1;
    end
  end

  // Phase transitions.
  always_comb begin
    priority if (do_new) begin
      phase_nxt = thkr_pkg::PH_UNDECIDED;
    end else if (do_hold) begin
      phase_nxt = thkr_pkg::PH_HELD;
    end else if (do_tap || do_end) begin
      phase_nxt = thkr_pkg::PH_IDLE;
    end else begin
      phase_nxt = phase_r;
    end
  end

  // Result fields and record updates.
  always_comb begin
    pending_row_nxt      = pending_row_r;
    pending_col_nxt      = pending_col_r;
    pending_is_layer_nxt = pending_is_layer_r;
    pending_mods_nxt     = pending_mods_r;
    pending_layer_nxt    = pending_layer_r;
    pending_tap_code_nxt = pending_tap_code_r;
    press_time_nxt       = press_time_r;
    kept_mods_nxt        = kept_mods_r;
    kept_layer_nxt       = kept_layer_r;
    kept_is_layer_nxt    = kept_is_layer_r;
    rel_pend_nxt         = rel_pend_r;
    release_code_nxt     = release_code_r;
    tap_time_nxt         = tap_time_r;
    tap_cnt_nxt          = 1'b0;
    ha_nxt               = thkr_pkg::HA_NONE;
    amods_nxt            = '0;
    alayer_nxt           = '0;
    ta_nxt               = thkr_pkg::TA_NONE;
    tcode_nxt            = '0;

    if (do_hold) begin
      if (pending_is_layer_r) begin
        kept_layer_nxt    = pending_layer_r;
        kept_is_layer_nxt = 1'b1;
        ha_nxt            = thkr_pkg::HA_LAYER_ON;
        alayer_nxt        = pending_layer_r;
      end else begin
        kept_mods_nxt     = pending_mods_r;
        kept_is_layer_nxt = 1'b0;
        ha_nxt            = thkr_pkg::HA_MODS_ON;
        amods_nxt         = pending_mods_r;
      end
    end
    if (do_end) begin
      if (kept_is_layer_r) begin
        ha_nxt     = thkr_pkg::HA_LAYER_OFF;
        alayer_nxt = kept_layer_r;
      end else begin
        ha_nxt    = thkr_pkg::HA_MODS_OFF;
        amods_nxt = kept_mods_r;
      end
    end
    if (do_new) begin
      pending_row_nxt      = it.key_row;
      pending_col_nxt      = it.key_col;
      pending_is_layer_nxt = it.is_layer;
      pending_mods_nxt     = it.hold_mod_mask;
      pending_layer_nxt    = it.hold_layer_num;
      pending_tap_code_nxt = it.tap_key_code;
      press_time_nxt       = it.now_ms;
    end
    if (do_tap) begin
      release_code_nxt = pending_tap_code_r;
      rel_pend_nxt     = 1'b1;
      tap_time_nxt     = it.now_ms;
      tap_cnt_nxt      = 1'b1;
      ta_nxt           = thkr_pkg::TA_REG;
      tcode_nxt        = pending_tap_code_r;
    end
    if (do_unreg) begin
      rel_pend_nxt = 1'b0;
      ta_nxt       = thkr_pkg::TA_UNREG;
      tcode_nxt    = release_code_r;
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r       <= thkr_pkg::TAPPING_TERM_RST;
      hold_other_r <= thkr_pkg::HOLD_OTHER_RST;
      timeout_r    <= thkr_pkg::TAP_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (thkr_pkg::thkr_cfg_idx_t'(cfg_idx))
        thkr_pkg::CFG_TAPPING_TERM: term_r       <= cfg_wdata;
        thkr_pkg::CFG_HOLD_OTHER:   hold_other_r <= cfg_wdata[0];
        thkr_pkg::CFG_TAP_TIMEOUT:  timeout_r    <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r            <= thkr_pkg::PH_IDLE;
      pending_row_r      <= '0;
      pending_col_r      <= '0;
      pending_is_layer_r <= 1'b0;
      pending_mods_r     <= '0;
      pending_layer_r    <= '0;
      pending_tap_code_r <= '0;
      press_time_r       <= '0;
      kept_mods_r        <= '0;
      kept_layer_r       <= '0;
      kept_is_layer_r    <= 1'b0;
      rel_pend_r         <= 1'b0;
      release_code_r     <= '0;
      tap_time_r         <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        phase_r            <= phase_nxt;
        pending_row_r      <= pending_row_nxt;
        pending_col_r      <= pending_col_nxt;
        pending_is_layer_r <= pending_is_layer_nxt;
        pending_mods_r     <= pending_mods_nxt;
        pending_layer_r    <= pending_layer_nxt;
        pending_tap_code_r <= pending_tap_code_nxt;
        press_time_r       <= press_time_nxt;
        kept_mods_r        <= kept_mods_nxt;
        kept_layer_r       <= kept_layer_nxt;
        kept_is_layer_r    <= kept_is_layer_nxt;
        rel_pend_r         <= rel_pend_nxt;
        release_code_r     <= release_code_nxt;
        tap_time_r         <= tap_time_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pass_r    <= pass_nxt;
      tap_cnt_r <= tap_cnt_nxt;
      ha_r      <= ha_nxt;
      amods_r   <= amods_nxt;
      alayer_r  <= alayer_nxt;
      ta_r      <= ta_nxt;
      tcode_r   <= tcode_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pass_on      = pass_r;
  assign out_ch.tap_counted  = tap_cnt_r;
  assign out_ch.hold_action  = ha_r;
  assign out_ch.action_mods  = amods_r;
  assign out_ch.action_layer = alayer_r;
  assign out_ch.tap_action   = ta_r;
  assign out_ch.tap_code_out = tcode_r;

  assign stat.phase           = phase_r;
  assign stat.release_pending = rel_pend_r;

endmodule

// File: sv/tap_hold_key_resolver.sv
// Tap/hold resolver for dual-role keys: one result per accepted request.
// A request is written into the queue, then resolved combinationally into the result
// register, where the result waits until the result channel takes it.
// Throughput: one request per cycle while the result channel is ready.
// Reset (synchronous, rst_n low): queue empty, phase idle, all records cleared,
// configuration back to 200 ms term, no hold on other press, 20 ms tap timeout.
module tap_hold_key_resolver #(
  parameter int unsigned QDEPTH = thkr_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  thkr_in_if.sink     in_ch,
  thkr_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_wdata
);

  thkr_pkg::thkr_qhead_t head;
  thkr_pkg::thkr_stat_t  stat;
  logic                  pop;

  thkr_front #(
    .QDEPTH (QDEPTH)
  ) u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .pop   (pop),
    .head  (head)
  );

  thkr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .head      (head),
    .pop       (pop),
    .out_ch    (out_ch),
    .stat      (stat)
  );

  // A tap is only registered from an undecided key.
  a_rel_from_undecided: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(stat.release_pending) |-> $past(stat.phase) == thkr_pkg::PH_UNDECIDED)
    else $error("release pending set without an undecided key");

  a_tap_counted_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.tap_counted |-> out_ch.tap_action == thkr_pkg::TA_REG)
    else $error("tap counted without tap registration");

  // Events passed on to the key handler never end a hold.
  a_pass_no_hold_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.pass_on |->
      out_ch.hold_action != thkr_pkg::HA_MODS_OFF &&
      out_ch.hold_action != thkr_pkg::HA_LAYER_OFF)
    else $error("passed-on event ended a hold");

  a_no_action_no_args: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.hold_action == thkr_pkg::HA_NONE |->
      out_ch.action_mods == 8'd0 && out_ch.action_layer == 4'd0)
    else $error("action arguments set without a hold action");

endmodule
